FILE: hdl/rau_pkg.sv
// Shared types and constants of the rational arithmetic unit.
`timescale 1ns / 1ps
`default_nettype none

package rau_pkg;

	// Fixed widths of the request and result fields.
	localparam int FIELD_W   = 32;
	localparam int RES_W     = 64;
	localparam int REQ_W     = 3;

	// Default operand width and depth of the queue between front and back.
	localparam int OPERAND_W_DEF = 32;
	localparam int QUEUE_DEPTH   = 2;

	// Request codes as they arrive on req_type.
	localparam logic [REQ_W-1:0] REQ_ADD  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_SUB  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_MUL  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_DIV  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_SIMP = 3'd4;

	// Classified operation as handed from the front to the back.
	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_SIMP,
		OP_BAD
	} rau_op_t;

	// Sequencer states of the back end.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_GCD,
		ST_GROW,
		ST_SHRINK,
		ST_QUOT,
		ST_EMIT
	} rau_state_t;

endpackage : rau_pkg

`default_nettype wire

FILE: hdl/rau_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none

module rau_front #(
	parameter int OPERAND_WIDTH = rau_pkg::OPERAND_W_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire  [rau_pkg::REQ_W-1:0]             req_type,
	input  wire  [rau_pkg::FIELD_W-1:0]           a_num,
	input  wire  [rau_pkg::FIELD_W-1:0]           a_den,
	input  wire  [rau_pkg::FIELD_W-1:0]           b_num,
	input  wire  [rau_pkg::FIELD_W-1:0]           b_den,
	output logic                                  pop_valid,
	input  wire                                   pop_ready,
	output rau_pkg::rau_op_t                      pop_op,
	output logic signed [OPERAND_WIDTH-1:0]       pop_an,
	output logic signed [OPERAND_WIDTH-1:0]       pop_ad,
	output logic signed [OPERAND_WIDTH-1:0]       pop_bn,
	output logic signed [OPERAND_WIDTH-1:0]       pop_bd
);
	import rau_pkg::*;

	localparam int W     = OPERAND_WIDTH;
	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	rau_op_t             op_cls;
	rau_op_t             op_mem_q [QUEUE_DEPTH];
	logic signed [W-1:0] an_mem_q [QUEUE_DEPTH];
	logic signed [W-1:0] ad_mem_q [QUEUE_DEPTH];
	logic signed [W-1:0] bn_mem_q [QUEUE_DEPTH];
	logic signed [W-1:0] bd_mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                push;
	logic                pop;

	// Map the request code onto an operation; codes without meaning give an empty result.
	always_comb begin
		case (req_type)
			REQ_ADD:  op_cls = OP_ADD;
			REQ_SUB:  op_cls = OP_SUB;
			REQ_MUL:  op_cls = OP_MUL;
			REQ_DIV:  op_cls = OP_DIV;
			REQ_SIMP: op_cls = OP_SIMP;
			default:  op_cls = OP_BAD;
		endcase
	end

	// Queue handshake on both sides.
	assign in_stall  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign push      = in_valid && !in_stall;
	assign pop_valid = (count_q != '0);
	assign pop       = pop_valid && pop_ready;

	// Queue storage; operands keep only their low OPERAND_WIDTH bits.
	always_ff @(posedge clk) begin
		if (push) begin
			op_mem_q[wr_ptr_q] <= op_cls;
			an_mem_q[wr_ptr_q] <= $signed(a_num[W-1:0]);
			ad_mem_q[wr_ptr_q] <= $signed(a_den[W-1:0]);
			bn_mem_q[wr_ptr_q] <= $signed(b_num[W-1:0]);
			bd_mem_q[wr_ptr_q] <= $signed(b_den[W-1:0]);
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Head of the queue.
	assign pop_op = op_mem_q[rd_ptr_q];
	assign pop_an = an_mem_q[rd_ptr_q];
	assign pop_ad = ad_mem_q[rd_ptr_q];
	assign pop_bn = bn_mem_q[rd_ptr_q];
	assign pop_bd = bd_mem_q[rd_ptr_q];

endmodule : rau_front

`default_nettype wire

FILE: hdl/rau_back.sv
// Back end: cross products, Euclid gcd, exact quotients and the output register.
`timescale 1ns / 1ps
`default_nettype none

module rau_back #(
	parameter int OPERAND_WIDTH = rau_pkg::OPERAND_W_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   pop_valid,
	output logic                                  pop_ready,
	input  wire  rau_pkg::rau_op_t                pop_op,
	input  wire  signed [OPERAND_WIDTH-1:0]       pop_an,
	input  wire  signed [OPERAND_WIDTH-1:0]       pop_ad,
	input  wire  signed [OPERAND_WIDTH-1:0]       pop_bn,
	input  wire  signed [OPERAND_WIDTH-1:0]       pop_bd,
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output logic signed [rau_pkg::RES_W-1:0]      res_num,
	output logic signed [rau_pkg::RES_W-1:0]      res_den,
	output logic                                  gcd_zero_err
);
	import rau_pkg::*;

	localparam int W     = OPERAND_WIDTH;
	localparam int P_W   = 2 * W;
	localparam int CNT_W = $clog2(W);

	rau_state_t          state_q;
	rau_state_t          state_d;

	// Captured operands.
	rau_op_t             op_q;
	logic signed [W-1:0] an_q;
	logic signed [W-1:0] ad_q;
	logic signed [W-1:0] bn_q;
	logic signed [W-1:0] bd_q;

	// Cross products.
	logic signed [P_W-1:0] p0_q;
	logic signed [P_W-1:0] p1_q;
	logic signed [P_W-1:0] p2_q;
	logic signed [RES_W-1:0] e0;
	logic signed [RES_W-1:0] e1;
	logic signed [RES_W-1:0] e2;

	// Euclid on magnitudes; the signs of x and y swap on every remainder step.
	logic [W-1:0] u_q;
	logic [W-1:0] v_q;
	logic [W-1:0] t_q;
	logic [W-1:0] r_q;
	logic         sx_q;
	logic         sy_q;
	logic [W-1:0] r_next;
	logic         grow_ok;
	logic         shrink_last;

	// Restoring division of both magnitudes by the gcd.
	logic [W-1:0]     qa_q;
	logic [W-1:0]     qd_q;
	logic [W:0]       rema_q;
	logic [W:0]       remd_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W:0]       ra_sh;
	logic [W:0]       rd_sh;
	logic             ga;
	logic             gd;
	logic [W:0]       rema_n;
	logic [W:0]       remd_n;
	logic [W-1:0]     qa_n;
	logic [W-1:0]     qd_n;
	logic [W-1:0]     abs_an;
	logic [W-1:0]     abs_ad;
	logic [RES_W-1:0] qa_ext;
	logic [RES_W-1:0] qd_ext;

	// Finished result waiting for the output register.
	logic signed [RES_W-1:0] num_q;
	logic signed [RES_W-1:0] den_q;
	logic                    err_q;
	logic                    out_valid_q;
	logic                    out_free;
	logic                    take;

	assign pop_ready = (state_q == ST_IDLE);
	assign take      = pop_valid && pop_ready;
	assign out_free  = !out_valid_q || !out_stall;

	// Sign-extended products for the sums.
	assign e0 = RES_W'(p0_q);
	assign e1 = RES_W'(p1_q);
	assign e2 = RES_W'(p2_q);

	// One remainder step: grow t to the largest v*2^k within u, then subtract back down.
	assign grow_ok     = (t_q <= (u_q >> 1));
	assign r_next      = (r_q >= t_q) ? (r_q - t_q) : r_q;
	assign shrink_last = (t_q == v_q);

	// One quotient bit for each of the two divisions.
	assign ra_sh  = {rema_q[W-1:0], qa_q[W-1]};
	assign rd_sh  = {remd_q[W-1:0], qd_q[W-1]};
	assign ga     = (ra_sh >= {1'b0, u_q});
	assign gd     = (rd_sh >= {1'b0, u_q});
	assign rema_n = ga ? (ra_sh - {1'b0, u_q}) : ra_sh;
	assign remd_n = gd ? (rd_sh - {1'b0, u_q}) : rd_sh;
	assign qa_n   = {qa_q[W-2:0], ga};
	assign qd_n   = {qd_q[W-2:0], gd};
	assign qa_ext = RES_W'(qa_n);
	assign qd_ext = RES_W'(qd_n);

	// Magnitudes of A; the most negative value maps onto 2^(W-1).
	assign abs_an = an_q[W-1] ? W'(-an_q) : W'(an_q);
	assign abs_ad = ad_q[W-1] ? W'(-ad_q) : W'(ad_q);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					case (pop_op)
						OP_ADD, OP_SUB, OP_MUL, OP_DIV: state_d = ST_MUL;
						OP_SIMP:                        state_d = ST_GCD;
						default:                        state_d = ST_EMIT;
					endcase
				end
			end
			ST_MUL:  state_d = ST_SUM;
			ST_SUM:  state_d = ST_EMIT;
			ST_GCD: begin
				if (v_q != '0) begin
					state_d = ST_GROW;
				end else if (u_q == '0) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_QUOT;
				end
			end
			ST_GROW: begin
				if (!grow_ok) begin
					state_d = ST_SHRINK;
				end
			end
			ST_SHRINK: begin
				if (shrink_last) begin
					state_d = ST_GCD;
				end
			end
			ST_QUOT: begin
				if (cnt_q == '0) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath registers, advanced by the sequencer state.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					op_q  <= pop_op;
					an_q  <= pop_an;
					ad_q  <= pop_ad;
					bn_q  <= pop_bn;
					bd_q  <= pop_bd;
					u_q   <= pop_an[W-1] ? W'(-pop_an) : W'(pop_an);
					v_q   <= pop_ad[W-1] ? W'(-pop_ad) : W'(pop_ad);
					sx_q  <= pop_an[W-1];
					sy_q  <= pop_ad[W-1];
					num_q <= '0;
					den_q <= '0;
					err_q <= 1'b0;
				end
			end
			ST_MUL: begin
				p0_q <= an_q * ((op_q == OP_MUL) ? bn_q : bd_q);
				p1_q <= ad_q * ((op_q == OP_DIV) ? bn_q : bd_q);
				p2_q <= ad_q * bn_q;
			end
			ST_SUM: begin
				case (op_q)
					OP_ADD:  num_q <= e0 + e2;
					OP_SUB:  num_q <= e0 - e2;
					default: num_q <= e0;
				endcase
				den_q <= e1;
			end
			ST_GCD: begin
				if (v_q != '0) begin
					t_q <= v_q;
					r_q <= u_q;
				end else if (u_q == '0) begin
					num_q <= RES_W'(an_q);
					den_q <= RES_W'(ad_q);
					err_q <= 1'b1;
				end else begin
					qa_q   <= abs_an;
					qd_q   <= abs_ad;
					rema_q <= '0;
					remd_q <= '0;
					cnt_q  <= CNT_W'(W - 1);
				end
			end
			ST_GROW: begin
				if (grow_ok) begin
					t_q <= t_q << 1;
				end
			end
			ST_SHRINK: begin
				if (shrink_last) begin
					u_q  <= v_q;
					v_q  <= r_next;
					sx_q <= sy_q;
					sy_q <= sx_q;
				end else begin
					t_q <= t_q >> 1;
					r_q <= r_next;
				end
			end
			ST_QUOT: begin
				qa_q   <= qa_n;
				qd_q   <= qd_n;
				rema_q <= rema_n;
				remd_q <= remd_n;
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					// Quotients are exact; the sign of the gcd carries into both parts.
					num_q <= (an_q[W-1] ^ sx_q) ? -qa_ext : qa_ext;
					den_q <= (ad_q[W-1] ^ sx_q) ? -qd_ext : qd_ext;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			res_num      <= num_q;
			res_den      <= den_q;
			gcd_zero_err <= err_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule : rau_back

`default_nettype wire

FILE: hdl/rational_arith_unit.sv
// Top level of the rational arithmetic unit: request queue front end and compute back end.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+------------------------------------------
//   request | in_valid / in_stall  | req_type, a_num, a_den, b_num, b_den
//   result  | out_valid / out_stall| res_num, res_den, gcd_zero_err
//
// Add, subtract, multiply and divide pass through take, multiply, sum and emit in the back end,
// with the three parallel multipliers in the multiply step; unknown codes go from take to emit.
// Simplify runs a grow and a shrink pass for each Euclid remainder step, then divides both
// parts by the gcd in the shift-subtract units; zero over zero goes from gcd check to emit.
// Reset clears the queue, the sequencer and the output valid flag.
// The two-entry queue keeps taking requests, until it is full, while the back end waits on out_stall.
`timescale 1ns / 1ps
`default_nettype none

module rational_arith_unit #(
	parameter int OPERAND_WIDTH = rau_pkg::OPERAND_W_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_stall,
	input  wire  [rau_pkg::REQ_W-1:0]           req_type,
	input  wire  [rau_pkg::FIELD_W-1:0]         a_num,
	input  wire  [rau_pkg::FIELD_W-1:0]         a_den,
	input  wire  [rau_pkg::FIELD_W-1:0]         b_num,
	input  wire  [rau_pkg::FIELD_W-1:0]         b_den,
	output logic                                out_valid,
	input  wire                                 out_stall,
	output logic signed [rau_pkg::RES_W-1:0]    res_num,
	output logic signed [rau_pkg::RES_W-1:0]    res_den,
	output logic                                gcd_zero_err
);
	import rau_pkg::*;

	rau_op_t                           pop_op;
	logic                              pop_valid;
	logic                              pop_ready;
	logic signed [OPERAND_WIDTH-1:0]   pop_an;
	logic signed [OPERAND_WIDTH-1:0]   pop_ad;
	logic signed [OPERAND_WIDTH-1:0]   pop_bn;
	logic signed [OPERAND_WIDTH-1:0]   pop_bd;

	// Request intake and queue.
	rau_front #(
		.OPERAND_WIDTH (OPERAND_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.a_num     (a_num),
		.a_den     (a_den),
		.b_num     (b_num),
		.b_den     (b_den),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_op    (pop_op),
		.pop_an    (pop_an),
		.pop_ad    (pop_ad),
		.pop_bn    (pop_bn),
		.pop_bd    (pop_bd)
	);

	// Arithmetic, gcd reduction and result register.
	rau_back #(
		.OPERAND_WIDTH (OPERAND_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_op       (pop_op),
		.pop_an       (pop_an),
		.pop_ad       (pop_ad),
		.pop_bn       (pop_bn),
		.pop_bd       (pop_bd),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.res_num      (res_num),
		.res_den      (res_den),
		.gcd_zero_err (gcd_zero_err)
	);

endmodule : rational_arith_unit

`default_nettype wire

FILE: test/rau_checker.sv
// Result checker for the rational arithmetic unit: predicts every transaction and compares.
`timescale 1ns / 1ps

module rau_result_checker #(
	parameter int OPERAND_WIDTH = rau_pkg::OPERAND_W_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	input  wire                          in_stall,
	input  wire [rau_pkg::REQ_W-1:0]     req_type,
	input  wire [rau_pkg::FIELD_W-1:0]   a_num,
	input  wire [rau_pkg::FIELD_W-1:0]   a_den,
	input  wire [rau_pkg::FIELD_W-1:0]   b_num,
	input  wire [rau_pkg::FIELD_W-1:0]   b_den,
	input  wire                          out_valid,
	input  wire                          out_stall,
	input  wire signed [rau_pkg::RES_W-1:0] res_num,
	input  wire signed [rau_pkg::RES_W-1:0] res_den,
	input  wire                          gcd_zero_err,
	output int                           mismatch_count,
	output int                           awaited_count
);
	import rau_pkg::*;

	typedef struct {
		longint num;
		longint den;
		logic   err;
	} fraction_t;

	// Fractions predicted for accepted requests, oldest first.
	fraction_t pending_fractions[$];
	int faults;

	// The operand is the low OPERAND_WIDTH bits of the field, sign extended.
	function automatic longint operand_value(input logic [FIELD_W-1:0] raw);
		longint v;
		v = longint'(raw);
		v = v <<< (64 - OPERAND_WIDTH);
		v = v >>> (64 - OPERAND_WIDTH);
		return v;
	endfunction

	// Euclid with a truncating remainder, so the sign of the gcd follows the operands.
	function automatic longint euclid_gcd(input longint x, input longint y);
		longint r;
		while (y != 0) begin
			r = x % y;
			x = y;
			y = r;
		end
		return x;
	endfunction

	// Exact fraction that one request should produce.
	function automatic fraction_t rational_result(input logic [REQ_W-1:0] op,
			input logic [FIELD_W-1:0] an_raw, input logic [FIELD_W-1:0] ad_raw,
			input logic [FIELD_W-1:0] bn_raw, input logic [FIELD_W-1:0] bd_raw);
		fraction_t f;
		longint an, ad, bn, bd, g;
		an = operand_value(an_raw);
		ad = operand_value(ad_raw);
		bn = operand_value(bn_raw);
		bd = operand_value(bd_raw);
		f.num = 0;
		f.den = 0;
		f.err = 1'b0;
		case (op)
			REQ_ADD: begin
				f.num = an * bd + ad * bn;
				f.den = ad * bd;
			end
			REQ_SUB: begin
				f.num = an * bd - ad * bn;
				f.den = ad * bd;
			end
			REQ_MUL: begin
				f.num = an * bn;
				f.den = ad * bd;
			end
			REQ_DIV: begin
				f.num = an * bd;
				f.den = ad * bn;
			end
			REQ_SIMP: begin
				g = euclid_gcd(an, ad);
				if (g == 0) begin
					// Zero over zero cannot be reduced: A comes back with the error flag.
					f.num = an;
					f.den = ad;
					f.err = 1'b1;
				end else begin
					f.num = an / g;
					f.den = ad / g;
				end
			end
			default: begin
				// Unknown codes give an all-zero result.
			end
		endcase
		return f;
	endfunction

	function automatic void report_field(input string field, input longint want,
			input longint got);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
	endfunction

	// Compare each result transaction with the oldest prediction, then queue new ones.
	always @(posedge clk or negedge arst_n) begin : channel_watch
		fraction_t want;
		if (!arst_n) begin
			pending_fractions.delete();
			faults = 0;
			mismatch_count <= 0;
			awaited_count <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_fractions.size() == 0) begin
					$display("%0t: result with none expected, actual %0d/%0d err %0b",
						$time, res_num, res_den, gcd_zero_err);
					faults++;
				end else begin
					want = pending_fractions.pop_front();
					if (res_num !== want.num) begin
						report_field("res_num", want.num, res_num);
						faults++;
					end
					if (res_den !== want.den) begin
						report_field("res_den", want.den, res_den);
						faults++;
					end
					if (gcd_zero_err !== want.err) begin
						report_field("gcd_zero_err", want.err, gcd_zero_err);
						faults++;
					end
				end
			end
			if (in_valid && !in_stall)
				pending_fractions.push_back(rational_result(req_type, a_num, a_den,
					b_num, b_den));
			mismatch_count <= faults;
			awaited_count <= pending_fractions.size();
		end
	end

endmodule

FILE: test/tb_rational_arith_unit.sv
// Testbench top for the rational arithmetic unit: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_rational_arith_unit;
	import rau_pkg::*;

	localparam int RESET_CYCLES   = 11;
	localparam int IDLE_PCT       = 26;
	localparam int RANDOM_ITEMS   = 430;
	localparam int HOLD_CYCLES    = 250;
	localparam int HOLD_AT        = 60;
	localparam int QUIET_FROM     = 180;
	localparam int QUIET_TO       = 280;
	localparam int DRAIN_AT       = 330;
	localparam int SETTLE_CYCLES  = 100;
	localparam int WATCHDOG_LIMIT = 5000;

	// Codes past simplify; the block answers them with a zero result.
	localparam logic [REQ_W-1:0] REQ_BAD5 = 3'd5;
	localparam logic [REQ_W-1:0] REQ_BAD6 = 3'd6;
	localparam logic [REQ_W-1:0] REQ_BAD7 = 3'd7;

	// Largest operand magnitudes; the most negative value is outside the range.
	localparam logic [FIELD_W-1:0] POS_MAX = 32'h7FFF_FFFF;
	localparam logic [FIELD_W-1:0] NEG_MAX = 32'h8000_0001;
	localparam logic [FIELD_W-1:0] NEG_OUT = 32'h8000_0000;

	typedef struct {
		logic [REQ_W-1:0]   op;
		logic [FIELD_W-1:0] an;
		logic [FIELD_W-1:0] ad;
		logic [FIELD_W-1:0] bn;
		logic [FIELD_W-1:0] bd;
	} fraction_req_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	wire                       in_stall;
	logic [REQ_W-1:0]          req_type;
	logic [FIELD_W-1:0]        a_num;
	logic [FIELD_W-1:0]        a_den;
	logic [FIELD_W-1:0]        b_num;
	logic [FIELD_W-1:0]        b_den;
	wire                       out_valid;
	logic                      out_stall;
	wire signed [RES_W-1:0]    res_num;
	wire signed [RES_W-1:0]    res_den;
	wire                       gcd_zero_err;
	int                        mismatch_count;
	int                        awaited_count;
	logic                      quiet;
	logic                      hold_go;

	fraction_req_t requests[$];

	rational_arith_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.a_num        (a_num),
		.a_den        (a_den),
		.b_num        (b_num),
		.b_den        (b_den),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.res_num      (res_num),
		.res_den      (res_den),
		.gcd_zero_err (gcd_zero_err)
	);

	rau_result_checker result_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.a_num          (a_num),
		.a_den          (a_den),
		.b_num          (b_num),
		.b_den          (b_den),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.res_num        (res_num),
		.res_den        (res_den),
		.gcd_zero_err   (gcd_zero_err),
		.mismatch_count (mismatch_count),
		.awaited_count  (awaited_count)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic queue_req(input logic [REQ_W-1:0] op, input logic [FIELD_W-1:0] an,
			input logic [FIELD_W-1:0] ad, input logic [FIELD_W-1:0] bn,
			input logic [FIELD_W-1:0] bd);
		fraction_req_t r;
		r.op = op;
		r.an = an;
		r.ad = ad;
		r.bn = bn;
		r.bd = bd;
		requests.push_back(r);
	endtask

	// Operands lean toward zero, the extremes and small values, with full-range noise.
	function automatic logic [FIELD_W-1:0] pick_operand();
		logic [FIELD_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = '0;
			1: v = POS_MAX;
			2: v = NEG_MAX;
			3, 4: v = $urandom_range(0, 200) - 100;
			default: v = $urandom;
		endcase
		if (v == NEG_OUT)
			v = NEG_MAX;
		return v;
	endfunction

	function automatic fraction_req_t random_request();
		fraction_req_t r;
		int unsigned pick;
		int k, x, y;
		pick = $urandom_range(0, 19);
		r.an = pick_operand();
		r.ad = pick_operand();
		r.bn = pick_operand();
		r.bd = pick_operand();
		if (pick < 4)
			r.op = REQ_ADD;
		else if (pick < 8)
			r.op = REQ_SUB;
		else if (pick < 11)
			r.op = REQ_MUL;
		else if (pick < 14)
			r.op = REQ_DIV;
		else if (pick < 19)
			r.op = REQ_SIMP;
		else
			r.op = REQ_W'($urandom_range(REQ_BAD5, REQ_BAD7));
		// Half of the simplify requests share a sizable common factor.
		if (r.op == REQ_SIMP && $urandom_range(0, 1) == 1) begin
			k = $urandom_range(1, 65535);
			x = $urandom_range(0, 65534) - 32767;
			y = $urandom_range(0, 65534) - 32767;
			if ($urandom_range(0, 1) == 1)
				k = -k;
			r.an = k * x;
			r.ad = k * y;
		end
		return r;
	endfunction

	// Offer one request transaction and wait until it is taken.
	task automatic offer(input fraction_req_t r);
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= r.op;
		a_num <= r.an;
		a_den <= r.ad;
		b_num <= r.bn;
		b_den <= r.bd;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Request side: directed cases, then random traffic with a hold-off and a drain pause.
	initial begin : request_side
		int n;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		req_type <= REQ_ADD;
		a_num <= '0;
		a_den <= '0;
		b_num <= '0;
		b_den <= '0;
		quiet <= 1'b0;
		hold_go <= 1'b0;

		queue_req(REQ_ADD, 1, 2, 1, 3);
		queue_req(REQ_ADD, POS_MAX, POS_MAX, POS_MAX, POS_MAX);
		queue_req(REQ_ADD, NEG_MAX, POS_MAX, NEG_MAX, POS_MAX);
		queue_req(REQ_ADD, 5, 0, 7, 0);
		queue_req(REQ_SUB, POS_MAX, NEG_MAX, NEG_MAX, POS_MAX);
		queue_req(REQ_SUB, 3, 4, 3, 4);
		queue_req(REQ_MUL, POS_MAX, NEG_MAX, NEG_MAX, NEG_MAX);
		queue_req(REQ_MUL, 0, 0, 0, 0);
		// Zero divisor comes out as a zero denominator.
		queue_req(REQ_DIV, 1, 2, 0, 5);
		queue_req(REQ_DIV, NEG_MAX, POS_MAX, POS_MAX, NEG_MAX);
		// Zero over zero flags the error; B is ignored.
		queue_req(REQ_SIMP, 0, 0, 12345, -1);
		// Zero denominator reduces to one over zero.
		queue_req(REQ_SIMP, 5, 0, 0, 0);
		queue_req(REQ_SIMP, -5, 0, POS_MAX, NEG_MAX);
		queue_req(REQ_SIMP, 0, 7, 0, 0);
		queue_req(REQ_SIMP, 0, -7, 0, 0);
		// The gcd comes out negative here and flips both signs.
		queue_req(REQ_SIMP, 12, -18, 0, 0);
		// Consecutive Fibonacci numbers take the longest remainder chain.
		queue_req(REQ_SIMP, 1836311903, 1134903170, 0, 0);
		queue_req(REQ_SIMP, POS_MAX, NEG_MAX, 0, 0);
		queue_req(REQ_SIMP, NEG_MAX, NEG_MAX, 0, 0);
		queue_req(REQ_SIMP, 32'h5555_5555, 32'h2AAA_AAAB, 0, 0);
		queue_req(REQ_BAD5, 3, 4, 5, 6);
		queue_req(REQ_BAD6, POS_MAX, NEG_MAX, POS_MAX, NEG_MAX);
		queue_req(REQ_BAD7, -1, -1, -1, -1);
		for (n = 0; n < RANDOM_ITEMS; n++)
			requests.push_back(random_request());

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < requests.size(); n++) begin
			if (n == HOLD_AT)
				hold_go <= 1'b1;
			if (n == QUIET_FROM)
				quiet <= 1'b1;
			if (n == QUIET_TO)
				quiet <= 1'b0;
			// Pause until every outstanding result has come back.
			if (n == DRAIN_AT) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (awaited_count != 0)
					@(posedge clk);
			end
			offer(requests[n]);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited_count != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Result side: random stalls and one long hold-off so the block backs up.
	initial begin : result_side
		bit held;
		held = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_go && !held) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	// Watchdog: too many cycles without any transaction ends the run.
	initial begin : watchdog
		int still;
		still = 0;
		while (still < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				still = 0;
			else
				still++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: files.f
hdl/rau_pkg.sv
hdl/rau_front.sv
hdl/rau_back.sv
hdl/rational_arith_unit.sv
test/rau_checker.sv
test/tb_rational_arith_unit.sv
